>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// delayed implication
`define ASSERT_LAT3(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error("assertion failed: three-cycle implication");

`endif

>>> design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, codes and sizes of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	// capacity is 7 bits wide, so no slot at or above this is ever reachable
	localparam int POOL_LIMIT    = 128;
	// bitmap bits per priority-encoder group
	localparam int GROUP_W       = 16;

	localparam int CAP_W      = 7;
	localparam int IDX_IN_W   = 7;
	localparam int SLOT_W     = 6;
	localparam int CNT_W      = 32;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;

	localparam logic [1:0] STAT_OK               = 2'd0;
	localparam logic [1:0] STAT_INVALID_STATE    = 2'd1;
	localparam logic [1:0] STAT_INVALID_ARGUMENT = 2'd2;
	localparam logic [1:0] STAT_EXHAUSTED        = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCRUB    = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

>>> design/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer: accept one word, run the bitmap scan, then the state update.
// ----------------------------------------------------------------------------
module spa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spa_pkg::dp_stat_t stat,
	output spa_pkg::cmd_t     cmd
);

	spa_pkg::state_t state_q;
	spa_pkg::state_t state_nxt;

	// hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// advance through scan and update; wait in update while the result slot is full
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spa_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = spa_pkg::ST_SCAN;
			end
			spa_pkg::ST_SCAN: begin
				state_nxt = spa_pkg::ST_EXEC;
			end
			spa_pkg::ST_EXEC: begin
				if (!stat.out_busy) state_nxt = spa_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = spa_pkg::ST_IDLE;
			end
		endcase
	end

	// drive commands and input stall
	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			spa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			spa_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			spa_pkg::ST_EXEC: begin
				cmd.exec = !stat.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> design/spa_datapath.sv
// ----------------------------------------------------------------------------
// spa_datapath
// Held bitmap, grouped first-free search, statistics and result register.
// ----------------------------------------------------------------------------
module spa_datapath #(
	parameter int MAX_SLOTS = spa_pkg::MAX_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spa_pkg::cmd_t                   cmd,
	output spa_pkg::dp_stat_t               stat,
	input  logic                            cfg_we,
	input  logic [spa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [1:0]                      opcode,
	input  logic [spa_pkg::IDX_IN_W-1:0]    slot_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [spa_pkg::SLOT_W-1:0]      slot,
	output logic                            scrub_slot,
	output logic [spa_pkg::CAP_W-1:0]       live_count,
	output logic [spa_pkg::CAP_W-1:0]       free_count,
	output logic [spa_pkg::CAP_W-1:0]       high_watermark,
	output logic [spa_pkg::CNT_W-1:0]       acquire_count,
	output logic [spa_pkg::CNT_W-1:0]       release_count,
	output logic [spa_pkg::CNT_W-1:0]       exhausted_count,
	output logic [spa_pkg::CNT_W-1:0]       double_release_count
);

	localparam int POOL  = (MAX_SLOTS < spa_pkg::POOL_LIMIT) ? MAX_SLOTS : spa_pkg::POOL_LIMIT;
	localparam int IDX_W = $clog2(POOL);
	localparam int GW    = spa_pkg::GROUP_W;
	localparam int LW    = $clog2(GW);
	localparam int NGRP  = (POOL + GW - 1) / GW;
	localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PAD   = NGRP * GW;
	localparam int CW    = spa_pkg::CAP_W;
	localparam int NW    = spa_pkg::CNT_W;

	// configuration
	logic [CW-1:0] capacity_q;
	logic          scrub_q;

	// pool state
	logic [POOL-1:0] held_q;
	logic [CW-1:0]   live_q;
	logic [CW-1:0]   peak_q;
	logic [NW-1:0]   grants_q;
	logic [NW-1:0]   returns_q;
	logic [NW-1:0]   refusals_q;
	logic [NW-1:0]   bad_q;

	// captured request
	logic [1:0]                   op_q;
	logic [spa_pkg::IDX_IN_W-1:0] idx_q;

	// scan stage
	logic [NGRP-1:0]        grp_any_s1;
	logic [LW-1:0]          grp_idx_s1 [NGRP];
	logic [NGRP-1:0]        grp_any;
	logic [LW-1:0]          grp_idx    [NGRP];
	logic [PAD-1:0]         free_vec;
	logic [CW-1:0]          cap_eff;

	// update stage
	logic [GRP_W-1:0]       sel_g;
	logic [LW-1:0]          sel_l;
	logic [GRP_W+LW-1:0]    grant_full;
	logic [CW-1:0]          grant7;
	logic                   found;
	logic                   in_range;
	logic                   held_bit;
	logic [POOL-1:0]        held_nxt;
	logic [CW-1:0]          live_nxt;
	logic [CW-1:0]          peak_nxt;
	logic [NW-1:0]          grants_nxt;
	logic [NW-1:0]          returns_nxt;
	logic [NW-1:0]          refusals_nxt;
	logic [NW-1:0]          bad_nxt;
	logic [1:0]             st_nxt;
	logic [spa_pkg::SLOT_W-1:0] slot_nxt;
	logic                   scrub_nxt;
	logic [CW-1:0]          free_nxt;
	logic                   out_valid_q;

	// saturate capacity to MAX_SLOTS
	always_comb begin
		if ({2'b00, capacity_q} > 9'(MAX_SLOTS)) begin
			cap_eff = CW'(MAX_SLOTS);
		end else begin
			cap_eff = capacity_q;
		end
	end

	// mark free slots below the effective capacity
	always_comb begin
		for (int i = 0; i < PAD; i++) begin
			if (i < POOL) begin
				free_vec[i] = !held_q[i] && (8'(i) < {1'b0, cap_eff});
			end else begin
				free_vec[i] = 1'b0;
			end
		end
	end

	// find lowest free bit within each group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			for (int b = GW - 1; b >= 0; b--) begin
				if (free_vec[g*GW + b]) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = LW'(b);
				end
			end
		end
	end

	// register group results
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			grp_any_s1 <= grp_any;
			for (int g = 0; g < NGRP; g++) begin
				grp_idx_s1[g] <= grp_idx[g];
			end
		end
	end

	// pick lowest group holding a free slot
	always_comb begin
		sel_g = '0;
		sel_l = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				sel_g = GRP_W'(g);
				sel_l = grp_idx_s1[g];
			end
		end
	end

	assign found      = |grp_any_s1;
	assign grant_full = {sel_g, sel_l};
	assign grant7     = CW'(grant_full);
	assign in_range   = idx_q < cap_eff;
	assign held_bit   = held_q[idx_q[IDX_W-1:0]];

	// work out the operation outcome
	always_comb begin
		held_nxt     = held_q;
		live_nxt     = live_q;
		peak_nxt     = peak_q;
		grants_nxt   = grants_q;
		returns_nxt  = returns_q;
		refusals_nxt = refusals_q;
		bad_nxt      = bad_q;
		st_nxt       = spa_pkg::STAT_OK;
		slot_nxt     = idx_q[spa_pkg::SLOT_W-1:0];
		scrub_nxt    = 1'b0;
		if (cap_eff == '0) begin
			st_nxt = spa_pkg::STAT_INVALID_STATE;
			if (op_q == spa_pkg::OP_ACQUIRE) slot_nxt = '0;
		end else begin
			case (op_q)
				spa_pkg::OP_ACQUIRE: begin
					slot_nxt = '0;
					if (found) begin
						held_nxt[grant_full[IDX_W-1:0]] = 1'b1;
						live_nxt   = CW'(live_q + 1'b1);
						grants_nxt = NW'(grants_q + 1'b1);
						slot_nxt   = grant7[spa_pkg::SLOT_W-1:0];
					end else begin
						refusals_nxt = NW'(refusals_q + 1'b1);
						st_nxt       = spa_pkg::STAT_EXHAUSTED;
					end
				end
				spa_pkg::OP_RELEASE: begin
					if (!in_range) begin
						st_nxt = spa_pkg::STAT_INVALID_ARGUMENT;
					end else if (!held_bit) begin
						bad_nxt = NW'(bad_q + 1'b1);
						st_nxt  = spa_pkg::STAT_INVALID_STATE;
					end else begin
						held_nxt[idx_q[IDX_W-1:0]] = 1'b0;
						if (live_q != '0) live_nxt = CW'(live_q - 1'b1);
						returns_nxt = NW'(returns_q + 1'b1);
						scrub_nxt   = scrub_q;
					end
				end
				spa_pkg::OP_CHECK: begin
					if (!in_range || !held_bit) st_nxt = spa_pkg::STAT_INVALID_ARGUMENT;
				end
				default: begin
					st_nxt = spa_pkg::STAT_INVALID_ARGUMENT;
				end
			endcase
		end
		if (live_nxt > peak_q) peak_nxt = live_nxt;
		free_nxt = (cap_eff > live_nxt) ? CW'(cap_eff - live_nxt) : '0;
	end

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			scrub_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				spa_pkg::REG_CAPACITY: capacity_q <= cfg_data;
				spa_pkg::REG_SCRUB:    scrub_q    <= cfg_data[0];
				default:               scrub_q    <= scrub_q;
			endcase
		end
	end

	// commit pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			live_q     <= '0;
			peak_q     <= '0;
			grants_q   <= '0;
			returns_q  <= '0;
			refusals_q <= '0;
			bad_q      <= '0;
		end else if (cmd.exec) begin
			held_q     <= held_nxt;
			live_q     <= live_nxt;
			peak_q     <= peak_nxt;
			grants_q   <= grants_nxt;
			returns_q  <= returns_nxt;
			refusals_q <= refusals_nxt;
			bad_q      <= bad_nxt;
		end
	end

	// capture request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			idx_q <= slot_index;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status               <= st_nxt;
			slot                 <= slot_nxt;
			scrub_slot           <= scrub_nxt;
			live_count           <= live_nxt;
			free_count           <= free_nxt;
			high_watermark       <= peak_nxt;
			acquire_count        <= grants_nxt;
			release_count        <= returns_nxt;
			exhausted_count      <= refusals_nxt;
			double_release_count <= bad_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_busy = out_valid_q && out_stall;

endmodule

>>> design/slot_pool_allocator.sv
// Each accepted word passes capture, grouped bitmap scan, then state update, which
// registers its result word; the input stalls until the update step completes.
// A result word waiting on out_stall holds the update step until it is taken.
// Reset (arst_n low) clears the held bitmap, live count, watermark, counters and
// both configuration registers at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// slot_pool_allocator
// First-free slot pool with statistics, controller plus datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slot_pool_allocator #(
	parameter int MAX_SLOTS = spa_pkg::MAX_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [spa_pkg::IDX_IN_W-1:0]    slot_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [spa_pkg::SLOT_W-1:0]      slot,
	output logic                            scrub_slot,
	output logic [spa_pkg::CAP_W-1:0]       live_count,
	output logic [spa_pkg::CAP_W-1:0]       free_count,
	output logic [spa_pkg::CAP_W-1:0]       high_watermark,
	output logic [spa_pkg::CNT_W-1:0]       acquire_count,
	output logic [spa_pkg::CNT_W-1:0]       release_count,
	output logic [spa_pkg::CNT_W-1:0]       exhausted_count,
	output logic [spa_pkg::CNT_W-1:0]       double_release_count
);

	spa_pkg::cmd_t     cmd;
	spa_pkg::dp_stat_t stat;

	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	spa_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.opcode               (opcode),
		.slot_index           (slot_index),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.status               (status),
		.slot                 (slot),
		.scrub_slot           (scrub_slot),
		.live_count           (live_count),
		.free_count           (free_count),
		.high_watermark       (high_watermark),
		.acquire_count        (acquire_count),
		.release_count        (release_count),
		.exhausted_count      (exhausted_count),
		.double_release_count (double_release_count)
	);

	// one word in flight: an accept closes the input for the next cycle
	`ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)
	// with the output empty, a result follows an accept after the scan and update
	`ASSERT_LAT3(a_result_latency, in_valid && !in_stall && !out_valid, out_valid)
	// scrubbing is only requested by a successful release
	`ASSERT_IMP(a_scrub_ok, out_valid && scrub_slot, status == spa_pkg::STAT_OK)
	// exhaustion leaves no free slot to report
	`ASSERT_IMP(a_exhaust_free, out_valid && status == spa_pkg::STAT_EXHAUSTED, free_count == '0)

endmodule
